/* design/palr_pkg.sv */
// Shared types and codes for the indexed palette recolor block.
package palr_pkg;

  // Request modes
  localparam logic [2:0] MODE_PIXEL   = 3'd0;
  localparam logic [2:0] MODE_NORMAL  = 3'd1;
  localparam logic [2:0] MODE_WEAPON  = 3'd2;
  localparam logic [2:0] MODE_RAMP    = 3'd3;
  localparam logic [2:0] MODE_ROW     = 3'd4;
  localparam logic [2:0] MODE_ROW_PRS = 3'd5;
  localparam logic [2:0] MODE_MAP     = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_PASS_DIST = 3'd0;
  localparam logic [2:0] CFG_PAL_LEN   = 3'd1;
  localparam logic [2:0] CFG_MAP_W     = 3'd2;
  localparam logic [2:0] CFG_MAP_H     = 3'd3;
  localparam logic [2:0] CFG_MAP_EN    = 3'd4;

  // Result paths
  localparam logic [1:0] PATH_INDEX0 = 2'd0;
  localparam logic [1:0] PATH_BODY   = 2'd1;
  localparam logic [1:0] PATH_REMAP  = 2'd2;
  localparam logic [1:0] PATH_PASS   = 2'd3;

  localparam logic [7:0] MAP_NO_DATA = 8'd255;
  localparam int         ROW_LEN     = 16;

  // Search token that moves down the palette cell chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic        armor;
    logic [9:0]  diff;
    logic [23:0] color;
  } tok_t;

endpackage

/* design/palr_cell.sv */
// One palette cell: holds a normal palette entry and updates the nearest-match token.
module palr_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [23:0]      wr_rgb_i,
  input  logic             wr_armor_i,
  input  logic             active_i,
  input  logic [23:0]      pix_rgb_i,
  input  palr_pkg::tok_t   tok_i,
  input  logic [IW-1:0]    best_i,
  output palr_pkg::tok_t   tok_o,
  output logic [IW-1:0]    best_o
);

  logic [23:0]    color_q;
  logic           armor_q;
  palr_pkg::tok_t tok_q;
  logic [IW-1:0]  best_q;
  logic [8:0]     dr, dg, db;
  logic [9:0]     dsum;
  logic           take;

  function automatic logic [8:0] adiff(input logic [7:0] a, input logic [7:0] b);
    adiff = (a > b) ? 9'(a - b) : 9'(b - a);
  endfunction

  assign dr   = adiff(pix_rgb_i[23:16], color_q[23:16]);
  assign dg   = adiff(pix_rgb_i[15:8], color_q[15:8]);
  assign db   = adiff(pix_rgb_i[7:0], color_q[7:0]);
  assign dsum = 10'(dr) + 10'(dg) + 10'(db);
  assign take = active_i && tok_i.valid && (!tok_i.found || dsum < tok_i.diff);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      color_q <= wr_rgb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armor_q <= 1'b0;
      tok_q   <= '0;
      best_q  <= '0;
    end else begin
      if (wr_en_i) begin
        armor_q <= wr_armor_i;
      end
      tok_q.valid <= tok_i.valid;
      // Replace the payload with this entry when it is active and nothing was found yet or it is strictly closer
      if (take) begin
        tok_q.found <= 1'b1;
        tok_q.armor <= armor_q;
        tok_q.diff  <= dsum;
        tok_q.color <= color_q;
        best_q      <= IW'(IDX);
      end else begin
        tok_q.found <= tok_i.found;
        tok_q.armor <= tok_i.armor;
        tok_q.diff  <= tok_i.diff;
        tok_q.color <= tok_i.color;
        best_q      <= best_i;
      end
    end
  end

  assign tok_o  = tok_q;
  assign best_o = best_q;

endmodule

/* design/indexed_palette_recolor_core.sv */
// Top level of the indexed palette recolor block: control, tables and cell chain.
// Flow: a table request completes when accepted; a pixel request reads the map and goes
//   to S_OUT on the index-0 path, via S_FETCH and S_EMIT on the body-row path, else via
//   the cell chain and S_DECIDE (plus S_FETCH, S_EMIT for a weapon palette read).
// Throughput: one request at a time; the nearest-color search walks the chain of
//   PALETTE_ENTRIES cells one cell per cycle, which sets the pixel rate.
// Reset: asynchronous, active low; config registers take their defaults, presence bits
//   and ramp lengths clear; color tables and the index map hold nothing until written.
module indexed_palette_recolor_core #(
  parameter int PALETTE_ENTRIES = 16,
  parameter int WEAPON_COUNT    = 16,
  parameter int MAP_WIDTH_MAX   = 64,
  parameter int MAP_HEIGHT_MAX  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic [7:0]         alpha_in_i,
  input  logic [3:0]         weapon_i,
  input  logic [3:0]         entry_i,
  input  logic               flag_i,
  input  logic [7:0]         map_value_i,
  input  logic [4:0]         ramp_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  output logic [7:0]         alpha_out_o,
  output logic [1:0]         path_taken_o
);

  localparam int IW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int WIW   = (WEAPON_COUNT > 1) ? $clog2(WEAPON_COUNT) : 1;
  localparam int TDEP  = WEAPON_COUNT * palr_pkg::ROW_LEN;
  localparam int TAW   = $clog2(TDEP);
  localparam int MDEP  = MAP_WIDTH_MAX * MAP_HEIGHT_MAX;
  localparam int MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;

  // Controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_CHAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [9:0] ptd_q;
  logic [4:0] plen_q;
  logic [6:0] mw_q, mh_q;
  logic       men_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptd_q  <= 10'd48;
      plen_q <= 5'd0;
      mw_q   <= 7'd64;
      mh_q   <= 7'd64;
      men_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        palr_pkg::CFG_PASS_DIST: ptd_q  <= cfg_data_i;
        palr_pkg::CFG_PAL_LEN:   plen_q <= cfg_data_i[4:0];
        palr_pkg::CFG_MAP_W:     mw_q   <= cfg_data_i[6:0];
        palr_pkg::CFG_MAP_H:     mh_q   <= cfg_data_i[6:0];
        palr_pkg::CFG_MAP_EN:    men_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accept requests only while idle
  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  logic        wok_in;
  logic [23:0] rgb_in;
  logic [TAW-1:0] tab_waddr;
  assign wok_in    = 32'(weapon_i) < WEAPON_COUNT;
  assign rgb_in    = {red_in_i, green_in_i, blue_in_i};
  assign tab_waddr = TAW'({weapon_i, entry_i});

  // Map position check against the current map size
  logic [10:0]    wlim, hlim;
  logic           map_in;
  logic [MAW-1:0] map_addr;
  assign wlim   = (11'(mw_q) < 11'(MAP_WIDTH_MAX)) ? 11'(mw_q) : 11'(MAP_WIDTH_MAX);
  assign hlim   = (11'(mh_q) < 11'(MAP_HEIGHT_MAX)) ? 11'(mh_q) : 11'(MAP_HEIGHT_MAX);
  assign map_in = !pos_x_i[11] && !pos_y_i[11] &&
                  (pos_x_i[10:0] < wlim) && (pos_y_i[10:0] < hlim);
  assign map_addr = MAW'(32'(pos_y_i[10:0]) * MAP_WIDTH_MAX + 32'(pos_x_i[10:0]));

  // Held pixel request
  logic [23:0]   rgb_q;
  logic [7:0]    alpha_q;
  logic [3:0]    wpn_q;
  logic          wok_q;
  logic          map_hit_q;
  logic [3:0]    idx_q;
  logic          sel_body_q;
  logic [23:0]   res_q;
  logic [1:0]    path_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rgb_q     <= rgb_in;
      alpha_q   <= alpha_in_i;
      wpn_q     <= weapon_i;
      wok_q     <= wok_in;
      map_hit_q <= men_q && map_in;
    end
  end

  // Index map: write on map bytes, read on every accepted request
  logic [7:0] map_mem [MDEP];
  logic [7:0] map_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (mode_i == palr_pkg::MODE_MAP && map_in) begin
        map_mem[map_addr] <= map_value_i;
      end
      map_rd_q <= map_mem[map_addr];
    end
  end

  // Per-weapon ramp and body-row flags
  logic [4:0] ramp_len_q  [WEAPON_COUNT];
  logic       ramp_pres_q [WEAPON_COUNT];
  logic       body_pres_q [WEAPON_COUNT];
  logic [WIW-1:0] wsel_in, wsel_q;
  assign wsel_in = WIW'(weapon_i);
  assign wsel_q  = WIW'(wpn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WEAPON_COUNT; i++) begin
        ramp_len_q[i]  <= 5'd0;
        ramp_pres_q[i] <= 1'b0;
        body_pres_q[i] <= 1'b0;
      end
    end else if (in_acc && wok_in) begin
      if (mode_i == palr_pkg::MODE_RAMP) begin
        ramp_len_q[wsel_in]  <= (ramp_length_i > 5'd16) ? 5'd16 : ramp_length_i;
        ramp_pres_q[wsel_in] <= flag_i;
      end
      if (mode_i == palr_pkg::MODE_ROW_PRS) begin
        body_pres_q[wsel_in] <= flag_i;
      end
    end
  end

  // Cell chain for the nearest normal palette entry
  palr_pkg::tok_t chain_tok  [PALETTE_ENTRIES+1];
  logic [IW-1:0]  chain_best [PALETTE_ENTRIES+1];
  logic           inject;

  assign chain_tok[0].valid = inject;
  assign chain_tok[0].found = 1'b0;
  assign chain_tok[0].armor = 1'b0;
  assign chain_tok[0].diff  = '0;
  assign chain_tok[0].color = '0;
  assign chain_best[0]      = '0;

  logic [PALETTE_ENTRIES-1:0] cell_valid;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    palr_cell #(.IDX(i), .IW(IW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (in_acc && mode_i == palr_pkg::MODE_NORMAL && 32'(entry_i) == i),
      .wr_rgb_i   (rgb_in),
      .wr_armor_i (flag_i),
      .active_i   (i < 32'(plen_q)),
      .pix_rgb_i  (rgb_q),
      .tok_i      (chain_tok[i]),
      .best_i     (chain_best[i]),
      .tok_o      (chain_tok[i+1]),
      .best_o     (chain_best[i+1])
    );
    assign cell_valid[i] = chain_tok[i+1].valid;
  end

  palr_pkg::tok_t fin_q;
  logic [6:0]     best_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CHAIN && chain_tok[PALETTE_ENTRIES].valid) begin
      fin_q  <= chain_tok[PALETTE_ENTRIES];
      best_q <= 7'(chain_best[PALETTE_ENTRIES]);
    end
  end

  // Weapon palettes and body rows, both read through registered ports
  logic [23:0]    wpal_mem [TDEP];
  logic [23:0]    body_mem [TDEP];
  logic [23:0]    wpal_rd_q, body_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && wok_in && mode_i == palr_pkg::MODE_WEAPON) begin
      wpal_mem[tab_waddr] <= rgb_in;
    end
    if (in_acc && wok_in && mode_i == palr_pkg::MODE_ROW) begin
      body_mem[tab_waddr] <= rgb_in;
    end
    wpal_rd_q <= wpal_mem[TAW'({wpn_q, best_q[3:0]})];
    body_rd_q <= body_mem[TAW'({wpn_q, idx_q})];
  end

  // Path decisions
  logic map_valid, use_body, match, use_wpal, ramp_ok;
  assign map_valid = map_hit_q && (map_rd_q != palr_pkg::MAP_NO_DATA);
  assign use_body  = map_valid && (map_rd_q[7:4] != 4'd0) && wok_q && body_pres_q[wsel_q];
  assign match     = fin_q.found && (fin_q.diff <= ptd_q) && fin_q.armor;
  assign use_wpal  = wok_q && ramp_pres_q[wsel_q];
  assign ramp_ok   = (best_q < 7'(ramp_len_q[wsel_q])) && (best_q < 7'(palr_pkg::ROW_LEN));

  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    inject  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i == palr_pkg::MODE_PIXEL) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        // index 0 and body rows skip the search
        priority if (map_valid && map_rd_q[7:4] == 4'd0) begin
          state_d = S_OUT;
        end else if (use_body) begin
          state_d = S_FETCH;
        end else begin
          inject  = 1'b1;
          state_d = S_CHAIN;
        end
      end
      S_CHAIN: begin
        if (chain_tok[PALETTE_ENTRIES].valid) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (match && use_wpal && ramp_ok) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FETCH: state_d = S_EMIT;
      S_EMIT:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Build the pending result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MAP: begin
        idx_q      <= map_rd_q[7:4];
        sel_body_q <= 1'b1;
        res_q      <= rgb_q;
        path_q     <= palr_pkg::PATH_INDEX0;
      end
      S_DECIDE: begin
        sel_body_q <= 1'b0;
        priority if (!match) begin
          res_q  <= rgb_q;
          path_q <= palr_pkg::PATH_PASS;
        end else if (!use_wpal) begin
          res_q  <= fin_q.color;
          path_q <= palr_pkg::PATH_REMAP;
        end else begin
          res_q  <= rgb_q;
          path_q <= palr_pkg::PATH_PASS;
        end
      end
      S_EMIT: begin
        res_q  <= sel_body_q ? body_rd_q : wpal_rd_q;
        path_q <= sel_body_q ? palr_pkg::PATH_BODY : palr_pkg::PATH_REMAP;
      end
      default: ;
    endcase
  end

  // Output register: hold until taken
  logic        out_valid_q;
  logic [23:0] out_rgb_q;
  logic [7:0]  out_alpha_q;
  logic [1:0]  out_path_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_rgb_q   <= res_q;
      out_alpha_q <= alpha_q;
      out_path_q  <= path_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_rgb_q[23:16];
  assign green_out_o  = out_rgb_q[15:8];
  assign blue_out_o   = out_rgb_q[7:0];
  assign alpha_out_o  = out_alpha_q;
  assign path_taken_o = out_path_q;

  // Checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_valid))
    else $error("more than one search token in the cell chain");

  a_chain_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid != '0) |-> (state_q == S_CHAIN))
    else $error("search token outside the search state");

  a_out_from_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

endmodule
